// ===== hw/rtl/spq_pkg.sv =====
`timescale 1ns / 1ps
// spq_pkg: shared types and constants of the sorted priority queue
// no dependencies; used by sorted_priority_queue, spq_checker and testbench

package spq_pkg;

	// default queue depth
	localparam int DEPTH_DEF = 16;

	// payload widths fixed by the interface
	localparam int VALUE_W  = 32;
	localparam int PRIO_W   = 16;
	localparam int STATUS_W = 2;
	localparam int ENTRY_W  = VALUE_W + PRIO_W;

	// operation codes
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_POP    = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// control sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_POP_WAIT,
		S_INS_SCAN,
		S_INS_HEAD
	} state_t;

endpackage

// ===== hw/rtl/spq_ram.sv =====
`timescale 1ns / 1ps
// spq_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies

module spq_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// sorted_priority_queue: bounded priority queue, entries kept sorted in one ram
// depends on spq_pkg and spq_ram
//
// Usage: a command is taken at a rising edge with start high and busy low.
// cmd selects insert (entry_value, entry_priority) or pop of the front entry.
// Each command gives exactly one result, shown for one cycle with done high:
// status, front_value (popped value, zero otherwise) and item_count (entries
// held after the command). The receiver cannot stall; results must be taken
// in the cycle that done is high. A new command may be started in that cycle.
// Entries live in a circular buffer in one ram, highest priority at the head;
// equal priorities leave in arrival order.
// An insert into an empty queue, a rejected insert and a pop on an empty
// queue give their result directly from idle. A pop first waits for one ram
// read. An insert into a non-empty queue walks backward from the tail, moving
// one entry per cycle through the single read port until it meets an equal
// or higher priority, or passes all n entries and is written at the head.
// Reset: asynchronous, active low; the queue is empty after reset. The ram
// needs no clearing since only slots holding entries are ever read.

module sorted_priority_queue #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               cmd,
	input  logic signed [spq_pkg::VALUE_W-1:0] entry_value,
	input  logic [spq_pkg::PRIO_W-1:0]         entry_priority,
	output logic                               done,
	output logic [spq_pkg::STATUS_W-1:0]       status,
	output logic signed [spq_pkg::VALUE_W-1:0] front_value,
	output logic [$clog2(DEPTH+1)-1:0]         item_count
);

	import spq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// circular index helpers
	function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] p);
		logic [AW-1:0] r;
		if (p == AW'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] p);
		logic [AW-1:0] r;
		if (p == '0) begin
			r = AW'(DEPTH - 1);
		end else begin
			r = p - 1'b1;
		end
		return r;
	endfunction

	state_t state_q, state_d;

	logic [AW-1:0]     head_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     idx_q;
	logic [CW-1:0]     left_q;
	logic [VALUE_W-1:0] val_q;
	logic [PRIO_W-1:0] prio_q;

	logic               done_q;
	logic [STATUS_W-1:0] status_q;
	logic [VALUE_W-1:0] front_q;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;

	logic [PRIO_W-1:0]  rd_prio;
	logic [VALUE_W-1:0] rd_value;
	logic [AW:0]        last_sum;
	logic [AW-1:0]      last_idx;
	logic               full;
	logic               empty;

	// sequencer strobes
	logic               take;
	logic               scan_load;
	logic               scan_step;
	logic               res_en;
	logic [STATUS_W-1:0] res_status;
	logic               res_front;
	logic               cnt_inc;
	logic               pop_fin;

	spq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_prio  = ram_rdata[VALUE_W +: PRIO_W];
	assign rd_value = ram_rdata[VALUE_W-1:0];
	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);

	// slot of the tail entry, head + count - 1 wrapped
	assign last_sum = {1'b0, head_q} + (AW+1)'(count_q) - 1'b1;
	assign last_idx = (last_sum >= (AW+1)'(DEPTH)) ?
		AW'(last_sum - (AW+1)'(DEPTH)) : last_sum[AW-1:0];

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, ram control and strobes
	always_comb begin
		state_d    = state_q;
		busy       = 1'b1;
		take       = 1'b0;
		scan_load  = 1'b0;
		scan_step  = 1'b0;
		res_en     = 1'b0;
		res_status = ST_DONE;
		res_front  = 1'b0;
		cnt_inc    = 1'b0;
		pop_fin    = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = idx_inc(idx_q);
		ram_wdata  = {prio_q, val_q};
		ram_re     = 1'b0;
		ram_raddr  = idx_dec(idx_q);
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					take = 1'b1;
					if (cmd == CMD_POP) begin
						if (empty) begin
							res_en     = 1'b1;
							res_status = ST_EMPTY;
						end else begin
							ram_re    = 1'b1;
							ram_raddr = head_q;
							state_d   = S_POP_WAIT;
						end
					end else if (full) begin
						res_en     = 1'b1;
						res_status = ST_FULL;
					end else if (empty) begin
						ram_we    = 1'b1;
						ram_waddr = head_q;
						ram_wdata = {entry_priority, entry_value};
						res_en    = 1'b1;
						cnt_inc   = 1'b1;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = last_idx;
						scan_load = 1'b1;
						state_d   = S_INS_SCAN;
					end
				end
			end
			S_POP_WAIT: begin
				res_en    = 1'b1;
				res_front = 1'b1;
				pop_fin   = 1'b1;
				state_d   = S_IDLE;
			end
			S_INS_SCAN: begin
				ram_we = 1'b1;
				if (rd_prio < prio_q) begin
					// move the stored entry one slot toward the tail
					ram_wdata = ram_rdata;
					if (left_q == CW'(1)) begin
						state_d = S_INS_HEAD;
					end else begin
						ram_re    = 1'b1;
						scan_step = 1'b1;
					end
				end else begin
					res_en  = 1'b1;
					cnt_inc = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_INS_HEAD: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				res_en    = 1'b1;
				cnt_inc   = 1'b1;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// queue bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cnt_inc) begin
			count_q <= count_q + 1'b1;
		end else if (pop_fin) begin
			count_q <= count_q - 1'b1;
			head_q  <= idx_inc(head_q);
		end
	end

	// scan position and latched command operands
	always_ff @(posedge clk) begin
		if (take) begin
			val_q  <= entry_value;
			prio_q <= entry_priority;
		end
		if (scan_load) begin
			idx_q  <= last_idx;
			left_q <= count_q;
		end else if (scan_step) begin
			idx_q  <= idx_dec(idx_q);
			left_q <= left_q - 1'b1;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res_en;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (res_en) begin
			status_q <= res_status;
			front_q  <= res_front ? rd_value : '0;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign front_value = front_q;
	assign item_count  = count_q;

	// occupancy stays within the queue depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("occupancy above depth");

	// the scan never reads and writes the same slot in one cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re && (ram_waddr == ram_raddr)))
		else $error("ram read and write to the same slot");

	// every result follows an accepted command or a busy cycle
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start || busy))
		else $error("result without a command");

	// a failed operation leaves the occupancy untouched
	a_reject_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_FULL || status == ST_EMPTY)) |->
			(count_q == $past(count_q)))
		else $error("rejected command changed occupancy");

	// while the scan is active, busy is high and entries are left to scan
	a_scan_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_SCAN) |-> busy && (left_q != '0))
		else $error("scan with no entries left");

endmodule

// ===== test/spq_checker.sv =====
`timescale 1ns / 1ps
// spq_checker: scoreboard for sorted_priority_queue; keeps a shadow copy of the
// sorted queue, predicts each result and compares it with the result strobe
// depends on spq_pkg

module spq_checker #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                busy,
	input  logic                                cmd,
	input  logic signed [spq_pkg::VALUE_W-1:0]  entry_value,
	input  logic [spq_pkg::PRIO_W-1:0]          entry_priority,
	input  logic                                done,
	input  logic [spq_pkg::STATUS_W-1:0]        status,
	input  logic signed [spq_pkg::VALUE_W-1:0]  front_value,
	input  logic [$clog2(DEPTH+1)-1:0]          item_count,
	output int                                  outstanding,
	output int                                  fail_count
);

	import spq_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef struct {
		logic [STATUS_W-1:0]      status;
		logic signed [VALUE_W-1:0] value;
		logic [CNT_W-1:0]         count;
	} spq_result_t;

	// shadow queue, slot 0 is the front
	logic signed [VALUE_W-1:0] held_value [DEPTH];
	logic [PRIO_W-1:0]         held_prio [DEPTH];
	int                        held_count;

	spq_result_t pending_results [$];
	spq_result_t want;
	int          errors = 0;

	assign fail_count = errors;

	// sorted insert behind equal or higher priorities, or removal of the front
	function automatic spq_result_t apply_command(input logic op,
			input logic signed [VALUE_W-1:0] v, input logic [PRIO_W-1:0] p);
		spq_result_t r;
		int pos;
		r.status = ST_DONE;
		r.value = '0;
		if (op == CMD_INSERT) begin
			if (held_count >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				pos = 0;
				while (pos < held_count && p <= held_prio[pos])
					pos++;
				for (int k = held_count; k > pos; k--) begin
					held_value[k] = held_value[k-1];
					held_prio[k] = held_prio[k-1];
				end
				held_value[pos] = v;
				held_prio[pos] = p;
				held_count++;
			end
		end else begin
			if (held_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.value = held_value[0];
				for (int k = 1; k < held_count; k++) begin
					held_value[k-1] = held_value[k];
					held_prio[k-1] = held_prio[k];
				end
				held_count--;
			end
		end
		r.count = CNT_W'(held_count);
		return r;
	endfunction

	// predict on every command transfer, compare on every result strobe
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count = 0;
			pending_results.delete();
			outstanding <= 0;
		end else begin
			if (start === 1'b1 && busy === 1'b0)
				pending_results.push_back(apply_command(cmd, entry_value, entry_priority));
			if (done === 1'b1) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result: status %0d front_value %0d item_count %0d",
						$time, status, front_value, item_count);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (status !== want.status) begin
						$display("%0t: status mismatch: expected %0d actual %0d",
							$time, want.status, status);
						errors++;
					end
					if (front_value !== want.value) begin
						$display("%0t: front_value mismatch: expected %0d actual %0d",
							$time, want.value, front_value);
						errors++;
					end
					if (item_count !== want.count) begin
						$display("%0t: item_count mismatch: expected %0d actual %0d",
							$time, want.count, item_count);
						errors++;
					end
				end
			end
			outstanding <= pending_results.size();
		end
	end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// testbench: stimulus and verdict for sorted_priority_queue
// depends on spq_pkg, sorted_priority_queue and spq_checker

module testbench;
	import spq_pkg::*;

	localparam int DEPTH        = DEPTH_DEF;
	localparam int CNT_W        = $clog2(DEPTH + 1);
	localparam int RANDOM_ITEMS = 900;
	localparam int TAIL_CYCLES  = DEPTH + 8;
	localparam int CYCLE_LIMIT  = 400000;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic                       busy;
	logic                       cmd = CMD_INSERT;
	logic signed [VALUE_W-1:0]  entry_value = '0;
	logic [PRIO_W-1:0]          entry_priority = '0;
	logic                       done;
	logic [STATUS_W-1:0]        status;
	logic signed [VALUE_W-1:0]  front_value;
	logic [CNT_W-1:0]           item_count;
	int                         outstanding;
	int                         fail_count;
	int                         cycles = 0;

	sorted_priority_queue #(.DEPTH(DEPTH)) DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.entry_value(entry_value), .entry_priority(entry_priority), .done(done),
		.status(status), .front_value(front_value), .item_count(item_count)
	);

	spq_checker #(.DEPTH(DEPTH)) result_check (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.entry_value(entry_value), .entry_priority(entry_priority), .done(done),
		.status(status), .front_value(front_value), .item_count(item_count),
		.outstanding(outstanding), .fail_count(fail_count)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// crowd priorities into a few values so ties are common
	function automatic logic [PRIO_W-1:0] pick_priority();
		int roll = $urandom_range(0, 99);
		if (roll < 40)
			return PRIO_W'($urandom_range(0, 7));
		if (roll < 50)
			return '0;
		if (roll < 60)
			return '1;
		return PRIO_W'($urandom_range(0, 65535));
	endfunction

	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 19))
			0: return {1'b1, {(VALUE_W-1){1'b0}}};
			1: return {1'b0, {(VALUE_W-1){1'b1}}};
			2: return '0;
			3: return '1;
			default: return $urandom();
		endcase
	endfunction

	// one command transfer, then an optional idle gap with start low
	task automatic issue(input logic op, input logic signed [VALUE_W-1:0] v,
			input logic [PRIO_W-1:0] p, input int gap);
		start <= 1'b1;
		cmd <= op;
		entry_value <= v;
		entry_priority <= p;
		do @(posedge clk); while (busy !== 1'b0);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		int mode;
		bit burst;
		int ins_pct;
		logic op;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: pop on empty, extremes and ties, fill, reject when full, then pops
		issue(CMD_POP, '1, '1, 0);
		issue(CMD_INSERT, {1'b0, {(VALUE_W-1){1'b1}}}, '0, 0);
		issue(CMD_INSERT, {1'b1, {(VALUE_W-1){1'b0}}}, '1, 1);
		issue(CMD_INSERT, 0, PRIO_W'(100), 0);
		issue(CMD_INSERT, -1, PRIO_W'(100), 0);
		issue(CMD_INSERT, 5, PRIO_W'(100), 2);
		issue(CMD_INSERT, 1234, '1, 0);
		issue(CMD_INSERT, -77, '0, 0);
		for (int i = 0; i < DEPTH - 7; i++)
			issue(CMD_INSERT, i * 1000 - 3, PRIO_W'(50 + (i % 3) * 50), i % 2);
		issue(CMD_INSERT, 42, '1, 0);
		issue(CMD_INSERT, 43, '0, 0);
		for (int i = 0; i < 6; i++)
			issue(CMD_POP, pick_value(), pick_priority(), i % 3);

		// random: fill, drain and balanced phases so full and empty recur
		mode = 0;
		burst = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if ($urandom_range(0, 39) == 0)
				mode = $urandom_range(0, 2);
			if ($urandom_range(0, 29) == 0)
				burst = !burst;
			case (mode)
				0: ins_pct = 80;
				1: ins_pct = 20;
				default: ins_pct = 50;
			endcase
			op = ($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_POP;
			issue(op, pick_value(), pick_priority(), burst ? 0 : pick_gap());
		end

		// drain outstanding results, then let the pipeline settle
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
